>>> rtl/core/jrfp_pkg.sv
// Shared types and constants for the joypad reply frame parser.
// This file has no dependencies. Every other file in rtl/core imports it.
package jrfp_pkg;

  // Number of 16-bit samples carried in the reply payload.
  localparam int SAMPLE_COUNT_DEFAULT = 6;

  localparam logic [7:0] HEAD_FIRST  = 8'h5A;  // 'Z'
  localparam logic [7:0] HEAD_SECOND = 8'h3A;  // ':'
  localparam logic [7:0] BYTE_MASK   = 8'hFF;
  localparam logic [8:0] POS_MAX     = 9'd511;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // One received byte of the SPI frame.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  // One parsed reply.
  typedef struct packed {
    logic        status;
    logic [15:0] left_x;
    logic [15:0] left_y;
    logic [15:0] right_x;
    logic [15:0] right_y;
    logic [15:0] left_trigger;
    logic [15:0] right_trigger;
  } out_t;

  // What the back end has to do with a byte.
  typedef enum logic [2:0] {
    OP_SKIP,
    OP_HEAD0,
    OP_HEAD1,
    OP_PAYLOAD,
    OP_CSUM_LO,
    OP_CSUM_HI
  } op_t;

  // Classified byte passed from the front end to the back end.
  typedef struct packed {
    op_t        op;
    logic       clear;  // frame start: drop header flag and running sum
    logic [7:0] data;
    logic [7:0] slot;   // byte offset within the payload
  } cmd_t;

endpackage

>>> rtl/core/jrfp_front.sv
// Front end of the joypad reply frame parser: byte position counter,
// offset register and byte classification. Depends on jrfp_pkg.
module jrfp_front import jrfp_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       offset_write,
  input  logic [7:0] offset_data,
  input  logic       accept,
  input  in_t        item,
  output logic       push,
  output cmd_t       cmd
);

  localparam int REL_CSUM_LO = 2 + 2 * SAMPLE_COUNT;
  localparam int REL_CSUM_HI = REL_CSUM_LO + 1;

  logic [7:0] reply_offset;
  logic [8:0] byte_position;
  logic [8:0] pos;
  logic [8:0] rel;

  always_comb begin
    pos = item.frame_start ? 9'd0 : byte_position;
    rel = pos - {1'b0, reply_offset};
    cmd.clear = item.frame_start;
    cmd.data  = item.data_byte & BYTE_MASK;
    cmd.slot  = rel[7:0] - 8'd2;
    if (pos < {1'b0, reply_offset}) begin
      cmd.op = OP_SKIP;
    end else if (rel == 9'd0) begin
      cmd.op = OP_HEAD0;
    end else if (rel == 9'd1) begin
      cmd.op = OP_HEAD1;
    end else if (rel < 9'(REL_CSUM_LO)) begin
      cmd.op = OP_PAYLOAD;
    end else if (rel == 9'(REL_CSUM_LO)) begin
      cmd.op = OP_CSUM_LO;
    end else if (rel == 9'(REL_CSUM_HI)) begin
      cmd.op = OP_CSUM_HI;
    end else begin
      cmd.op = OP_SKIP;
    end
    // Skipped bytes only need to reach the back end when they start a frame.
    push = accept && ((cmd.op != OP_SKIP) || cmd.clear);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_offset  <= 8'd0;
      byte_position <= 9'd0;
    end else begin
      if (offset_write) begin
        reply_offset <= offset_data;
      end
      if (accept && (pos < POS_MAX)) begin
        byte_position <= pos + 9'd1;
      end else if (accept) begin
        byte_position <= pos;
      end
    end
  end

endmodule

>>> rtl/core/jrfp_queue.sv
// Two-entry queue of classified bytes between the front and back ends.
// Depends on jrfp_pkg for the entry type.
module jrfp_queue import jrfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic empty,
  output cmd_t head
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> rtl/core/jrfp_back.sv
// Back end of the joypad reply frame parser: header check, payload sum,
// sample assembly and the registered result. Depends on jrfp_pkg.
module jrfp_back import jrfp_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  cmd_t head,
  output logic pop,
  output logic result_valid,
  input  logic result_stall,
  output out_t result_item
);

  localparam int IDX_W = $clog2(SAMPLE_COUNT);

  logic        header_good;
  logic        header_good_next;
  logic [15:0] payload_sum;
  logic [15:0] payload_sum_next;
  logic [7:0]  checksum_low;
  logic [15:0] sample_store [SAMPLE_COUNT];
  logic        hg_base;
  logic [15:0] sum_base;
  logic        ok;
  logic        out_free;
  logic [IDX_W-1:0] k;
  out_t        result_next;

  assign out_free = !result_valid || !result_stall;
  // A checksum-high byte waits until the result register can take it.
  assign pop = !empty && ((head.op != OP_CSUM_HI) || out_free);
  assign k   = head.slot[IDX_W:1];

  function automatic logic [15:0] axis(input logic [15:0] sample);
    axis = {sample[12:0], 3'b000};
  endfunction

  always_comb begin
    hg_base          = head.clear ? 1'b0 : header_good;
    sum_base         = head.clear ? 16'd0 : payload_sum;
    header_good_next = hg_base;
    payload_sum_next = sum_base;
    ok = hg_base && (sum_base[7:0] == checksum_low) && (sum_base[15:8] == head.data);
    case (head.op)
      OP_HEAD0: begin
        header_good_next = (head.data == HEAD_FIRST);
        payload_sum_next = 16'd0;
      end
      OP_HEAD1: begin
        header_good_next = hg_base && (head.data == HEAD_SECOND);
      end
      OP_PAYLOAD: begin
        payload_sum_next = sum_base + {8'd0, head.data};
      end
      default: begin
      end
    endcase
    if (ok) begin
      result_next.status        = STATUS_OK;
      result_next.left_x        = axis(sample_store[3]);
      result_next.left_y        = axis(sample_store[2]);
      result_next.right_x       = axis(sample_store[1]);
      result_next.right_y       = axis(sample_store[0]);
      result_next.left_trigger  = axis(sample_store[4]);
      result_next.right_trigger = axis(sample_store[5]);
    end else begin
      result_next = '0;
      result_next.status = STATUS_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.op == OP_PAYLOAD) begin
        if (head.slot[0]) begin
          sample_store[k][15:8] <= head.data;
        end else begin
          sample_store[k][7:0] <= head.data;
        end
      end
      if (head.op == OP_CSUM_LO) begin
        checksum_low <= head.data;
      end
      if (head.op == OP_CSUM_HI) begin
        result_item <= result_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_good  <= 1'b0;
      payload_sum  <= 16'd0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        header_good <= header_good_next;
        payload_sum <= payload_sum_next;
      end
      if (pop && (head.op == OP_CSUM_HI)) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/joypad_reply_frame_parser.sv
// Top level of the joypad reply frame parser: front end, queue and back end.
// Depends on jrfp_pkg, jrfp_front, jrfp_queue and jrfp_back.
//
// Usage. Bytes of a received SPI frame enter on the byte channel
// (byte_valid, byte_stall, byte_item); byte_item.frame_start marks the
// first byte of a frame. The block skips bytes up to the reply offset set
// through offset_write and offset_data, checks the 'Z', ':' header, sums
// the twelve payload bytes and compares the sum with the two checksum
// bytes. After the last checksum byte one request leaves on the result
// channel (result_valid, result_stall, result_item) carrying the status
// and six axes; on a bad message the axes are zero.
// Throughput is one byte per clock cycle while byte_stall is low. The
// front end classifies each byte in the cycle it is accepted and writes
// it into a two-entry queue unless it is a skipped byte that starts no
// frame; the back end takes one queue entry per cycle unless a
// checksum-high byte waits for the output. The result is registered: the
// last checksum byte passes the queue into the result register once the output is free.
// When the receiver stalls, the result register holds its request; the
// back end keeps working on bytes that produce no result, and byte_stall
// rises only when the queue is full. Reset clears the offset to zero, the
// byte position, the header flag, the running sum and both handshakes.
module joypad_reply_frame_parser import jrfp_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       offset_write,
  input  logic [7:0] offset_data,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  in_t        byte_item,
  output logic       result_valid,
  input  logic       result_stall,
  output out_t       result_item
);

  logic accept;
  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t push_cmd;
  cmd_t head;

  // The front end may only take a byte while the queue has room.
  assign byte_stall = full;
  assign accept     = byte_valid && !full;

  jrfp_front #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .offset_write (offset_write),
    .offset_data  (offset_data),
    .accept       (accept),
    .item         (byte_item),
    .push         (push),
    .cmd          (push_cmd)
  );

  jrfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  jrfp_back #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

>>> bench/joypad_reply_frame_parser_tb.sv
// Self-checking testbench for the joypad reply frame parser: a scoreboard
// class predicts each reply from the accepted bytes, plain tasks drive frames.
// Depends on jrfp_pkg and the joypad_reply_frame_parser RTL.
module joypad_reply_frame_parser_tb import jrfp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Reply layout relative to the header position.
  localparam int HEADER_BYTES  = 2;
  localparam int PAYLOAD_BYTES = 12;
  localparam int CSUM_LO_AT    = 14;
  localparam int CSUM_HI_AT    = 15;
  localparam int REPLY_BYTES   = 16;
  localparam int SHOWN_LIMIT   = 10;
  // The settling wait covers the result register and the two bytes that
  // can sit in the queue, so that the block is left idle.
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int ITEM_TARGET   = 1650;
  localparam int TIMEOUT_NS    = 2_000_000;

  typedef enum int {
    FAULT_NONE,
    FAULT_HEAD_FIRST,
    FAULT_HEAD_SECOND,
    FAULT_SUM_LOW,
    FAULT_SUM_HIGH
  } fault_t;

  // Tracks the parser state byte by byte and keeps the replies it predicts.
  class reply_scoreboard;
    logic [7:0]  offset;
    logic [8:0]  position;
    bit          header_ok;
    logic [15:0] running_sum;
    logic [15:0] samples [SAMPLE_COUNT_DEFAULT];
    logic [7:0]  sum_low;
    out_t        expected_replies [$];
    int          mismatches;
    int          checked;

    function new();
      offset      = '0;
      position    = '0;
      header_ok   = 1'b0;
      running_sum = '0;
      sum_low     = '0;
      mismatches  = 0;
      checked     = 0;
      foreach (samples[i]) samples[i] = '0;
    endfunction

    function void set_offset(logic [7:0] value);
      offset = value;
    endfunction

    function void note_byte(in_t item);
      int   rel;
      int   slot;
      bit   ok;
      out_t reply;
      if (item.frame_start) begin
        position    = '0;
        header_ok   = 1'b0;
        running_sum = '0;
      end
      if (position >= offset) begin
        rel = int'(position) - int'(offset);
        if (rel == 0) begin
          header_ok   = (item.data_byte == HEAD_FIRST);
          running_sum = '0;
        end else if (rel == 1) begin
          header_ok = header_ok && (item.data_byte == HEAD_SECOND);
        end else if (rel < CSUM_LO_AT) begin
          slot        = (rel - HEADER_BYTES) >> 1;
          running_sum = running_sum + 16'(item.data_byte);
          if (rel % 2 == 0) samples[slot][7:0] = item.data_byte;
          else samples[slot][15:8] = item.data_byte;
        end else if (rel == CSUM_LO_AT) begin
          sum_low = item.data_byte;
        end else if (rel == CSUM_HI_AT) begin
          ok = header_ok && (running_sum[7:0] == sum_low)
               && (running_sum[15:8] == item.data_byte);
          reply = '0;
          reply.status = ok ? STATUS_OK : STATUS_BAD;
          if (ok) begin
            reply.left_x        = samples[3] << 3;
            reply.left_y        = samples[2] << 3;
            reply.right_x       = samples[1] << 3;
            reply.right_y       = samples[0] << 3;
            reply.left_trigger  = samples[4] << 3;
            reply.right_trigger = samples[5] << 3;
          end
          expected_replies.push_back(reply);
        end
      end
      if (position < POS_MAX) position = position + 9'd1;
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= SHOWN_LIMIT)
          $display("reply %0d: %s expected %h, got %h", checked, field, want, got);
      end
    endfunction

    function void check_reply(out_t got);
      out_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_LIMIT)
          $display("reply with nothing expected: %h", got);
        return;
      end
      want = expected_replies.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("left_x", want.left_x, got.left_x);
      compare_field("left_y", want.left_y, got.left_y);
      compare_field("right_x", want.right_x, got.right_x);
      compare_field("right_y", want.right_y, got.right_y);
      compare_field("left_trigger", want.left_trigger, got.left_trigger);
      compare_field("right_trigger", want.right_trigger, got.right_trigger);
      checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic offset_write;
  logic [7:0] offset_data;
  logic byte_valid;
  logic byte_stall;
  in_t  byte_item;
  logic result_valid;
  logic result_stall;
  out_t result_item;

  reply_scoreboard sb;
  logic [7:0] payload_buf [PAYLOAD_BYTES];
  bit  need_start = 1'b0;
  bit  hold_off_req = 1'b0;
  int  burst_left = 0;
  int  items_sent = 0;
  int  frames_sent = 0;
  int  phases_run = 0;
  int  hold_offs_done = 0;
  int  stall_cycle = 0;
  int  stall_mode = 0;

  joypad_reply_frame_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .offset_write (offset_write),
    .offset_data  (offset_data),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offers one byte and returns at the edge that accepts it. The sender
  // works in bursts; between bursts valid drops for a random gap.
  task automatic send_byte(input logic [7:0] data, input logic start);
    in_t item;
    int  gap;
    item.data_byte   = data;
    item.frame_start = start | need_start;
    need_start       = 1'b0;
    if (burst_left == 0) begin
      byte_valid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
      case ($urandom_range(0, 9))
        0: burst_left = $urandom_range(100, 300);
        1, 2, 3, 4: burst_left = $urandom_range(9, 40);
        default: burst_left = $urandom_range(1, 8);
      endcase
    end
    byte_valid <= 1'b1;
    byte_item  <= item;
    @(posedge clk);
    while (byte_stall === 1'b1) @(posedge clk);
    sb.note_byte(item);
    burst_left--;
    items_sent++;
  endtask

  // Sends one frame: filler bytes up to the header, then reply_len bytes built
  // from payload_buf, then trailing bytes, ignored if the header is in place.
  task automatic send_reply(input int filler, input int reply_len, input fault_t fault,
                            input int trailing, input logic start);
    logic [7:0]  reply [REPLY_BYTES];
    logic [15:0] sum;
    sum = '0;
    foreach (payload_buf[i]) sum = sum + 16'(payload_buf[i]);
    reply[0] = HEAD_FIRST;
    reply[1] = HEAD_SECOND;
    foreach (payload_buf[i]) reply[HEADER_BYTES + i] = payload_buf[i];
    reply[CSUM_LO_AT] = sum[7:0];
    reply[CSUM_HI_AT] = sum[15:8];
    case (fault)
      FAULT_HEAD_FIRST:  reply[0] ^= 8'($urandom_range(1, 255));
      FAULT_HEAD_SECOND: reply[1] ^= 8'($urandom_range(1, 255));
      FAULT_SUM_LOW:     reply[CSUM_LO_AT] ^= 8'($urandom_range(1, 255));
      FAULT_SUM_HIGH:    reply[CSUM_HI_AT] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
    for (int i = 0; i < filler; i++) send_byte(8'($urandom), start && i == 0);
    for (int i = 0; i < reply_len; i++) send_byte(reply[i], start && filler == 0 && i == 0);
    for (int i = 0; i < trailing; i++) send_byte(8'($urandom), 1'b0);
    frames_sent++;
  endtask

  // Lowers valid and waits until every predicted reply has been checked.
  task automatic drain_replies();
    byte_valid <= 1'b0;
    burst_left = 0;
    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the offset; the next byte then opens a new frame, so a reply is
  // never assembled from samples left over from another offset.
  task automatic write_offset(input logic [7:0] value);
    offset_write <= 1'b1;
    offset_data  <= value;
    @(posedge clk);
    sb.set_offset(value);
    offset_write <= 1'b0;
    need_start = 1'b1;
  endtask

  // Receiver: a stall pattern that changes every so often, and on request a
  // long hold-off so that the queue fills and the input side stalls.
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_off_req = 1'b0;
        hold_offs_done++;
      end else begin
        if (stall_cycle % 97 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 99) < 30);
          2: result_stall <= ((stall_cycle % 5) < 2);
          default: result_stall <= ($urandom_range(0, 99) < 75);
        endcase
        stall_cycle++;
      end
    end
  end

  // Every request taken from the result channel is checked at once.
  always @(posedge clk) begin
    if (rst === 1'b0 && result_valid === 1'b1 && result_stall === 1'b0)
      sb.check_reply(result_item);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL joypad_reply_frame_parser");
    $finish;
  end

  initial begin
    logic [7:0] offset;
    int frames;
    int filler;
    int choice;
    int trailing;
    fault_t fault;
    sb = new();
    rst          <= 1'b1;
    offset_write <= 1'b0;
    offset_data  <= '0;
    byte_valid   <= 1'b0;
    byte_item    <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_offset(8'd0);

    // Directed: a good reply with every payload byte at its maximum, so the
    // sum carries into the high byte and every axis shift drops bits; then a
    // reply of zero samples cut short by the frame start that follows.
    foreach (payload_buf[i]) payload_buf[i] = 8'hFF;
    send_reply(0, REPLY_BYTES, FAULT_NONE, 0, 1'b1);
    foreach (payload_buf[i]) payload_buf[i] = 8'h00;
    send_reply(0, 8, FAULT_NONE, 0, 1'b1);
    drain_replies();

    // Random phases, each at one offset. The first ones take the largest
    // offset (with a frame long enough to saturate the position), the
    // smallest nonzero one and zero with a long hold-off.
    while (items_sent < ITEM_TARGET) begin
      phases_run++;
      case (phases_run)
        1: offset = 8'd255;
        2: offset = 8'd1;
        3: offset = 8'd0;
        default: begin
          choice = $urandom_range(0, 99);
          if (choice < 70) offset = 8'($urandom_range(0, 6));
          else if (choice < 85) offset = 8'($urandom_range(7, 40));
          else offset = 8'($urandom_range(200, 255));
        end
      endcase
      write_offset(offset);
      if (phases_run == 3 || $urandom_range(0, 5) == 0) hold_off_req = 1'b1;
      frames = (offset >= 100) ? 2 : $urandom_range(6, 14);
      for (int f = 0; f < frames; f++) begin
        foreach (payload_buf[i]) begin
          choice = $urandom_range(0, 9);
          payload_buf[i] = (choice == 0) ? 8'h00 : (choice == 1) ? 8'hFF : 8'($urandom);
        end
        trailing = (phases_run == 1 && f == 0) ? 330 : $urandom_range(0, 4);
        filler = offset;
        if ($urandom_range(0, 19) == 0) begin
          // Misplaced header: one byte early or late.
          if (offset > 0 && $urandom_range(0, 1) == 0) filler = offset - 1;
          else filler = offset + 1;
        end
        fault = ($urandom_range(0, 4) == 0) ? fault_t'($urandom_range(1, 4)) : FAULT_NONE;
        choice = $urandom_range(0, 99);
        if (choice < 8) begin
          // Noise: random bytes, now and then a frame start among them.
          repeat ($urandom_range(3, 20))
            send_byte(8'($urandom), ($urandom_range(0, 99) < 15));
        end else if (choice < 14) begin
          send_reply(filler, $urandom_range(1, REPLY_BYTES - 1), fault, 0, 1'b1);
        end else if (choice < 17) begin
          // Frame start missing: the positions run on from the last frame.
          send_reply(filler, REPLY_BYTES, fault, trailing, 1'b0);
        end else begin
          send_reply(filler, REPLY_BYTES, fault, trailing, 1'b1);
        end
      end
      drain_replies();
    end

    if (sb.expected_replies.size() != 0) begin
      $display("%0d predicted replies never arrived", sb.expected_replies.size());
      sb.mismatches += sb.expected_replies.size();
    end
    $display("Ran %0d frames (%0d bytes) over %0d offset phases, %0d long hold-offs.",
             frames_sent, items_sent, phases_run + 1, hold_offs_done);
    $display("Checked %0d replies, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS joypad_reply_frame_parser");
    end else begin
      $display("FAIL joypad_reply_frame_parser");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/jrfp_pkg.sv
rtl/core/jrfp_front.sv
rtl/core/jrfp_queue.sv
rtl/core/jrfp_back.sv
rtl/core/joypad_reply_frame_parser.sv
bench/joypad_reply_frame_parser_tb.sv
